// ----- rtl/drb_pkg.sv -----
// ----------------------------------------------------------------------------
// drb_pkg
// shared types and constants of the disc reveal bitmap
// ----------------------------------------------------------------------------
package drb_pkg;

  // widths of the beat fields
  localparam int KIND_W  = 2;
  localparam int XY_W    = 8;
  localparam int RADIN_W = 4;

  // signed working width of a row or column: 8-bit centre plus or minus a 4-bit radius
  localparam int COORD_W = 10;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_REVEAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // control from the sequencer to the row memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } drb_mem_ctl_t;

endpackage

// ----- rtl/disc_reveal_bitmap_core.sv -----
// ----------------------------------------------------------------------------
// disc_reveal_bitmap_core
// one-bit explored map with disc reveal, cell query and whole-map clear
// ----------------------------------------------------------------------------
// The map is GRID_DIM x GRID_DIM bits held as GRID_DIM row words in one
// synchronous memory, row x at address x, column y at bit y. Every input
// beat gives exactly one output beat; explored is the cell bit for a query
// (0 outside the grid) and 0 for every other kind. Items are handled one at
// a time: a reveal of radius r walks |dx| = 0..r, shrinking the half width w
// one step a cycle until w*w + dx*dx <= r*r, then does a read-modify-write
// of row cx+dx and of row cx-dx; a query reads row cx and takes bit cy. A
// result waits in ST_DONE until the output register is free, so an output
// stall holds the sequencer. Rows off the grid are skipped and columns are
// clipped by the span mask. Clear drops all row valid bits in a single
// cycle, so no clearing pass is needed after reset. A new beat is taken as
// soon as the sequencer is idle, even while the previous result still sits
// in the output register.
// ----------------------------------------------------------------------------
module disc_reveal_bitmap_core
  import drb_pkg::*;
#(
  parameter int GRID_DIM   = 128,
  parameter int MAX_RADIUS = 15
) (
  input  logic        clk,
  input  logic        rst,
  // input item
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // x_coord[7:0], y_coord[15:8], radius[19:16], zero pad
  input  logic [1:0]  s_tuser,   // kind[1:0]
  // result item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // explored[0], zero pad
);

  localparam int ROW_W = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int SAT_W = (RAD_W > RADIN_W) ? RAD_W : RADIN_W;
  localparam int SQ_W  = 2 * RAD_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Q_READ,
    ST_Q_DATA,
    ST_R_ADJ,
    ST_R_WPOS,
    ST_R_WNEG,
    ST_CLEAR,
    ST_DONE
  } state_t;

  state_t state;

  // item registers
  logic signed [COORD_W-1:0] cx;
  logic [XY_W-1:0]           cy;
  logic [RAD_W-1:0]          r_q;
  logic [SQ_W-1:0]           rr;
  logic                      q_ok;

  // reveal walk
  logic [RAD_W-1:0]          a;        // |dx|
  logic [RAD_W-1:0]          half_w;   // span half width for this |dx|
  logic [ROW_W-1:0]          row_pend; // row whose read is in flight
  logic                      row_ok;   // that row lies on the grid
  logic                      result;

  // memory interface
  drb_mem_ctl_t              mem_ctl;
  logic [ROW_W-1:0]          rd_addr;
  logic [GRID_DIM-1:0]       wr_data;
  logic [GRID_DIM-1:0]       rd_data;
  logic [GRID_DIM-1:0]       span;

  // incoming beat fields
  logic [KIND_W-1:0]         in_kind;
  logic [XY_W-1:0]           in_x;
  logic [XY_W-1:0]           in_y;
  logic [RADIN_W-1:0]        in_rad;
  logic [SAT_W-1:0]          rad_ext;
  logic [RAD_W-1:0]          r_sat;

  assign in_kind = s_tuser[1:0];
  assign in_x    = s_tdata[7:0];
  assign in_y    = s_tdata[15:8];
  assign in_rad  = s_tdata[19:16];

  // radius saturates at MAX_RADIUS
  assign rad_ext = SAT_W'(in_rad);
  assign r_sat   = (rad_ext > SAT_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(rad_ext);

  // rows cx+a and cx-a with their on-grid tests
  logic signed [COORD_W-1:0] a_s;
  logic signed [COORD_W-1:0] row_pos;
  logic signed [COORD_W-1:0] row_neg;
  logic                      pos_ok;
  logic                      neg_ok;

  assign a_s     = COORD_W'(a);
  assign row_pos = cx + a_s;
  assign row_neg = cx - a_s;
  assign pos_ok  = (row_pos >= 0) && (row_pos < $signed(COORD_W'(GRID_DIM)));
  assign neg_ok  = (row_neg >= 0) && (row_neg < $signed(COORD_W'(GRID_DIM)));

  // disc test for the current half width
  logic [SQ_W-1:0] w_sq;
  logic [SQ_W-1:0] a_sq;
  logic [SQ_W-1:0] sum_sq;
  logic            too_wide;

  assign w_sq     = SQ_W'(half_w) * SQ_W'(half_w);
  assign a_sq     = SQ_W'(a) * SQ_W'(a);
  assign sum_sq   = w_sq + a_sq;
  assign too_wide = sum_sq > rr;

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // memory control from the sequencer state
  always_comb begin
    mem_ctl = '0;
    rd_addr = row_pend;
    unique case (state)
      ST_Q_READ: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = cx[ROW_W-1:0];
      end
      ST_R_ADJ: begin
        mem_ctl.rd_en = !too_wide;
        rd_addr       = row_pos[ROW_W-1:0];
      end
      ST_R_WPOS: begin
        mem_ctl.wr_en = row_ok;
        mem_ctl.rd_en = (a != '0);
        rd_addr       = row_neg[ROW_W-1:0];
      end
      ST_R_WNEG: begin
        mem_ctl.wr_en = row_ok;
      end
      ST_CLEAR: begin
        mem_ctl.clr_all = 1'b1;
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  assign wr_data = rd_data | span;

  drb_span_mask #(
    .GRID_DIM (GRID_DIM),
    .RAD_W    (RAD_W)
  ) u_span (
    .cy     (cy),
    .half_w (half_w),
    .mask   (span)
  );

  drb_row_mem #(
    .GRID_DIM (GRID_DIM),
    .ROW_W    (ROW_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (row_pend),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // a taken beat empties the register unless the next result loads now
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cx     <= COORD_W'(in_x);
            cy     <= in_y;
            r_q    <= r_sat;
            rr     <= SQ_W'(r_sat) * SQ_W'(r_sat);
            // x and y bounds folded into the query flag
            q_ok   <= ((in_x < XY_W'(GRID_DIM - 1)) || (in_x == XY_W'(GRID_DIM - 1))) &&
                      !(in_y > XY_W'(GRID_DIM - 1));
            a      <= '0;
            half_w <= r_sat;
            result <= 1'b0;
            case (in_kind)
              KIND_REVEAL: state <= ST_R_ADJ;
              KIND_QUERY:  state <= ST_Q_READ;
              KIND_CLEAR:  state <= ST_CLEAR;
              default:     state <= ST_DONE;
            endcase
          end
        end
        ST_Q_READ: begin
          state <= ST_Q_DATA;
        end
        ST_Q_DATA: begin
          result <= q_ok && rd_data[cy[ROW_W-1:0]];
          state  <= ST_DONE;
        end
        ST_R_ADJ: begin
          if (too_wide) begin
            half_w <= half_w - 1'b1;
          end else begin
            row_pend <= row_pos[ROW_W-1:0];
            row_ok   <= pos_ok;
            state    <= ST_R_WPOS;
          end
        end
        ST_R_WPOS: begin
          if (a != '0) begin
            row_pend <= row_neg[ROW_W-1:0];
            row_ok   <= neg_ok;
            state    <= ST_R_WNEG;
          end else if (a == r_q) begin
            state <= ST_DONE;
          end else begin
            a     <= a + 1'b1;
            state <= ST_R_ADJ;
          end
        end
        ST_R_WNEG: begin
          if (a == r_q) begin
            state <= ST_DONE;
          end else begin
            a     <= a + 1'b1;
            state <= ST_R_ADJ;
          end
        end
        ST_CLEAR: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, result};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a row is written only in the reveal write steps
  a_wr_only_reveal: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |-> (state == ST_R_WPOS || state == ST_R_WNEG))
    else $error("row write outside reveal write step");

  // every written span lies inside the disc
  a_span_in_disc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_R_WPOS || state == ST_R_WNEG) |-> !too_wide)
    else $error("span half width exceeds disc");

  // walk never passes the radius
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_R_ADJ || state == ST_R_WPOS || state == ST_R_WNEG) |->
      (a <= r_q && half_w <= r_q))
    else $error("reveal walk beyond radius");

  // a result beat only starts from the finishing step
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result beat without finished item");

endmodule

// ----- rtl/drb_row_mem.sv -----
// ----------------------------------------------------------------------------
// drb_row_mem
// row-wide bitmap memory, one read and one write port, registered read,
// one valid flip-flop per row so a whole-map clear needs no pass over the rows
// ----------------------------------------------------------------------------
module drb_row_mem
  import drb_pkg::*;
#(
  parameter int GRID_DIM = 128,
  parameter int ROW_W    = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  drb_mem_ctl_t        ctl,
  input  logic [ROW_W-1:0]    rd_addr,
  input  logic [ROW_W-1:0]    wr_addr,
  input  logic [GRID_DIM-1:0] wr_data,
  output logic [GRID_DIM-1:0] rd_data
);

  logic [GRID_DIM-1:0] mem [GRID_DIM];
  logic [GRID_DIM-1:0] row_valid;
  logic [GRID_DIM-1:0] rd_q;
  logic                rd_valid_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read with write-first forwarding on a same-row collision
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      if (ctl.wr_en && (wr_addr == rd_addr)) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl.clr_all) begin
        row_valid <= '0;
      end else if (ctl.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid_q <= row_valid[rd_addr] || (ctl.wr_en && (wr_addr == rd_addr));
      end
    end
  end

  // a row never written since reset or the last clear reads as zero
  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// ----- rtl/drb_span_mask.sv -----
// ----------------------------------------------------------------------------
// drb_span_mask
// one row of the disc: columns cy-w .. cy+w, clipped to the grid
// ----------------------------------------------------------------------------
module drb_span_mask
  import drb_pkg::*;
#(
  parameter int GRID_DIM = 128,
  parameter int RAD_W    = 4
) (
  input  logic [XY_W-1:0]     cy,
  input  logic [RAD_W-1:0]    half_w,
  output logic [GRID_DIM-1:0] mask
);

  logic signed [COORD_W-1:0] lo;
  logic signed [COORD_W-1:0] hi;

  assign lo = $signed(COORD_W'(cy)) - $signed(COORD_W'(half_w));
  assign hi = $signed(COORD_W'(cy)) + $signed(COORD_W'(half_w));

  always_comb begin
    for (int j = 0; j < GRID_DIM; j++) begin
      mask[j] = ($signed(COORD_W'(j)) >= lo) && ($signed(COORD_W'(j)) <= hi);
    end
  end

endmodule
